@@ sv/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer slot pool package
// Shared constants, operation codes and state type for the timer slot pool.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int SLOTS     = 32;
    localparam int ID_MAX    = 63;
    localparam int N_USE     = (SLOTS > ID_MAX) ? ID_MAX : SLOTS;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W      = 6;
    localparam int TMO_W     = 32;
    localparam int NOW_W     = 63;
    localparam int SCALE_W   = 20;
    localparam int PROD_W    = TMO_W + SCALE_W;
    localparam logic [SCALE_W-1:0] NS_PER_MS = SCALE_W'(1000000);

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_RESTART = 2'd1,
        OP_CHECK   = 2'd2,
        OP_STOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB
    } t_state;

endpackage

@@ sv/tsp_free_enc.sv @@
// ----------------------------------------------------------------------------
// Timer slot pool free-slot encoder
// Finds the lowest usable slot whose busy flag is clear.
// ----------------------------------------------------------------------------
module tsp_free_enc (
    input  logic [tsp_pkg::SLOTS-1:0]  i_busy,
    output logic                       o_found,
    output logic [tsp_pkg::SLOT_W-1:0] o_idx
);
    import tsp_pkg::*;

    // scan from the top so that the lowest free slot wins
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = N_USE - 1; i >= 0; i--) begin
            if (!i_busy[i]) begin
                o_found = 1'b1;
                o_idx   = SLOT_W'(i);
            end
        end
    end

endmodule

@@ sv/timer_slot_pool_core.sv @@
// ----------------------------------------------------------------------------
// Timer slot pool core
// Pool of timer slots holding a millisecond timeout and a nanosecond deadline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one request: op, slot id,
//   timeout in ms and the current time in ns. Output channel
//   (o_valid / i_ready) returns exactly one result per request:
//   given slot, expired and failed flags.
//   Each request passes three steps: accept (memory read), multiply of the
//   timeout by 1e6 into a register, then add/saturate/compare with
//   write-back. The slot memories are read synchronously and the
//   multiplier is registered; a new request is taken only after the
//   previous one has written back.
//   The result sits in an output register, so the next request is accepted
//   while the previous result waits. If the receiver stalls and the output
//   register is still full, write-back holds until it drains.
//   Reset clears the state machine, the output valid flag and the per-slot
//   busy and deadline-valid flags; an entry without its flag reads as zero,
//   so both stores look cleared at once without a sweep.
// ----------------------------------------------------------------------------
module timer_slot_pool_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_op,
    input  logic [tsp_pkg::ID_W-1:0]   i_slot_id,
    input  logic [tsp_pkg::TMO_W-1:0]  i_timeout_ms,
    input  logic [tsp_pkg::NOW_W-1:0]  i_now_ns,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [tsp_pkg::ID_W-1:0]   o_given_slot,
    output logic                       o_expired,
    output logic                       o_failed
);
    import tsp_pkg::*;

    // slot stores: synchronous read
    logic [NOW_W-1:0]  r_dl_mem  [SLOTS];
    logic [TMO_W-1:0]  r_tmo_mem [SLOTS];

    // per-slot flags: busy means stored timeout is non-zero
    logic [SLOTS-1:0]  r_busy;
    logic [SLOTS-1:0]  r_dl_ok;

    t_state            r_state, n_state;

    // captured request
    t_op               r_op;
    logic [SLOT_W-1:0] r_idx;
    logic              r_id_ok;
    logic              r_id_zero;
    logic              r_found;
    logic [TMO_W-1:0]  r_tmo;
    logic [NOW_W-1:0]  r_now;

    // read data
    logic [NOW_W-1:0]  r_rd_dl;
    logic [TMO_W-1:0]  r_rd_tmo;
    logic              r_rd_dl_ok;
    logic              r_rd_busy;

    logic [PROD_W-1:0] r_prod;

    // output register
    logic              r_out_valid;
    logic [ID_W-1:0]   r_given;
    logic              r_expired;
    logic              r_failed;

    // control
    logic              accept;
    logic              do_mul;
    logic              do_wb;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              in_id_ok;
    logic [SLOT_W-1:0] in_idx;
    logic [SLOT_W-1:0] rd_addr;
    logic [TMO_W-1:0]  tmo_sel;
    logic [NOW_W:0]    sum;
    logic [NOW_W-1:0]  arm;
    logic [NOW_W-1:0]  dl_cur;
    logic              hit;
    logic              dl_we;
    logic              start_ok;

    tsp_free_enc u_free_enc (
        .i_busy  (r_busy),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    // ids are 1-based; anything outside 1..N_USE addresses no slot
    assign in_id_ok = (i_slot_id != '0) && (7'(i_slot_id) <= 7'(N_USE));
    assign in_idx   = SLOT_W'(i_slot_id - ID_W'(1));
    assign rd_addr  = (t_op'(i_op) == OP_START) ? free_idx : in_idx;

    // next state and handshake
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        do_mul  = 1'b0;
        do_wb   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                do_mul  = 1'b1;
                n_state = ST_WB;
            end
            ST_WB: begin
                if (!r_out_valid || i_ready) begin
                    do_wb   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture request and read both stores at the chosen slot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= t_op'(i_op);
            r_idx      <= (t_op'(i_op) == OP_START) ? free_idx : in_idx;
            r_id_ok    <= in_id_ok;
            r_id_zero  <= (i_slot_id == '0);
            r_found    <= free_found;
            r_tmo      <= i_timeout_ms;
            r_now      <= i_now_ns;
            r_rd_dl    <= r_dl_mem[rd_addr];
            r_rd_tmo   <= r_tmo_mem[rd_addr];
            r_rd_dl_ok <= r_dl_ok[rd_addr];
            r_rd_busy  <= r_busy[rd_addr];
        end
    end

    // restart uses the stored timeout; a free slot's timeout is zero
    assign tmo_sel = (r_op == OP_START) ? r_tmo : (r_rd_busy ? r_rd_tmo : '0);

    always_ff @(posedge i_clk) begin
        if (do_mul) begin
            r_prod <= PROD_W'(tmo_sel) * PROD_W'(NS_PER_MS);
        end
    end

    // deadline = now + timeout * 1e6, saturating at the top of 63 bits
    assign sum    = {1'b0, r_now} + (NOW_W + 1)'(r_prod);
    assign arm    = sum[NOW_W] ? '1 : sum[NOW_W-1:0];
    assign dl_cur = r_rd_dl_ok ? r_rd_dl : '0;
    assign hit    = (r_now >= dl_cur);

    assign start_ok = (r_op == OP_START) && r_found;
    assign dl_we    = do_wb && (start_ok || ((r_op == OP_RESTART) && r_id_ok));

    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            r_dl_mem[r_idx] <= arm;
        end
        if (do_wb && start_ok) begin
            r_tmo_mem[r_idx] <= r_tmo;
        end
    end

    // flag updates at write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_dl_ok <= '0;
        end else if (do_wb) begin
            if (dl_we) begin
                r_dl_ok[r_idx] <= 1'b1;
            end
            unique case (r_op)
                OP_START: begin
                    if (r_found) begin
                        r_busy[r_idx] <= (r_tmo != '0);
                    end
                end
                OP_CHECK: begin
                    if (r_id_ok && hit) begin
                        r_busy[r_idx]  <= 1'b0;
                        r_dl_ok[r_idx] <= 1'b0;
                    end
                end
                OP_STOP: begin
                    if (r_id_ok) begin
                        r_busy[r_idx]  <= 1'b0;
                        r_dl_ok[r_idx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_wb) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wb) begin
            r_given   <= start_ok ? (ID_W'(r_idx) + ID_W'(1)) : '0;
            r_failed  <= (r_op == OP_START) && !r_found;
            r_expired <= (r_op == OP_CHECK) && (r_id_zero || (r_id_ok && hit));
        end
    end

    assign o_valid      = r_out_valid;
    assign o_given_slot = r_given;
    assign o_expired    = r_expired;
    assign o_failed     = r_failed;

endmodule

@@ dv/tb_timer_slot_pool_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer slot pool core testbench
// Sends start, restart, check and stop requests through the valid/ready
// input channel. A directed table comes first, then random rounds that fill,
// drain or mix the pool. Each request the core takes runs through a local
// copy of the slot stores for the expected result, where the table gives
// none. Results are compared field by field, in order, as they leave the
// core. Both sides idle and stall at random; the receiver also holds off long.
// ----------------------------------------------------------------------------
module tb_timer_slot_pool_core;
    import tsp_pkg::*;

    localparam int DIR_N       = 25;
    localparam int RAND_ITEMS  = 750;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_WAIT  = 16;
    localparam logic [NOW_W-1:0] NS_MAX = '1;
    localparam logic [NOW_W-1:0] NS_DEEP_SAT = 63'h7FFF_FFFF_FFFF_0000;
    localparam logic [TMO_W-1:0] TMO_MAX = '1;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} t_mix;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_stall;

    typedef struct packed {
        logic [ID_W-1:0] given;
        logic            expired;
        logic            failed;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [TMO_W-1:0] tmo;
        logic [NOW_W-1:0] now;
        logic             typed;    // result written in the table
        t_result          want;
    } t_request;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_valid      = 1'b0;
    logic             o_ready;
    logic [1:0]       i_op         = '0;
    logic [ID_W-1:0]  i_slot_id    = '0;
    logic [TMO_W-1:0] i_timeout_ms = '0;
    logic [NOW_W-1:0] i_now_ns     = '0;
    logic             o_valid;
    logic             i_ready      = 1'b0;
    logic [ID_W-1:0]  o_given_slot;
    logic             o_expired;
    logic             o_failed;

    // travels alongside the payload so the monitor knows a table result
    logic             req_typed    = 1'b0;
    t_result          req_want     = '0;

    // local copy of the slot stores, both clear after reset
    logic [NOW_W-1:0] slot_deadline [SLOTS];
    logic [TMO_W-1:0] slot_timeout  [SLOTS];

    t_result          pending_results [$];
    t_request         directed [DIR_N];
    int               sent_n = 0;
    int               rcv_n  = 0;
    int               err_n  = 0;

    timer_slot_pool_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_slot_id    (i_slot_id),
        .i_timeout_ms (i_timeout_ms),
        .i_now_ns     (i_now_ns),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_given_slot (o_given_slot),
        .o_expired    (o_expired),
        .o_failed     (o_failed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            slot_deadline[s] = '0;
            slot_timeout[s]  = '0;
        end
    end

    // now + timeout in ns, clamped to the largest 63-bit value
    function automatic logic [NOW_W-1:0] deadline_after(logic [NOW_W-1:0] now,
                                                        logic [TMO_W-1:0] tmo);
        logic [NOW_W:0] sum;
        sum = {1'b0, now} + 64'(tmo) * 64'd1_000_000;
        return sum[NOW_W] ? NS_MAX : sum[NOW_W-1:0];
    endfunction

    // applies one request to the local stores, returns its result
    function automatic t_result timer_pool_step(t_op op, logic [ID_W-1:0] id,
                                                logic [TMO_W-1:0] tmo,
                                                logic [NOW_W-1:0] now);
        t_result r;
        logic    in_range;
        int      idx;
        int      s;
        r        = '0;
        in_range = (id >= 1) && (id <= N_USE);
        idx      = in_range ? int'(id) - 1 : 0;
        case (op)
            OP_START: begin
                r.failed = 1'b1;
                for (s = 0; s < N_USE && r.failed; s++) begin
                    if (slot_timeout[s] == '0) begin
                        // a zero timeout leaves the slot free
                        slot_timeout[s]  = tmo;
                        slot_deadline[s] = deadline_after(now, tmo);
                        r.given          = ID_W'(s + 1);
                        r.failed         = 1'b0;
                    end
                end
            end
            OP_RESTART: begin
                if (in_range)
                    slot_deadline[idx] = deadline_after(now, slot_timeout[idx]);
            end
            OP_CHECK: begin
                if (id == '0) begin
                    r.expired = 1'b1;
                end else if (in_range && now >= slot_deadline[idx]) begin
                    r.expired          = 1'b1;
                    slot_deadline[idx] = '0;
                    slot_timeout[idx]  = '0;
                end
            end
            default: begin
                if (in_range) begin
                    slot_deadline[idx] = '0;
                    slot_timeout[idx]  = '0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_request rq(t_op op, logic [ID_W-1:0] id,
                                    logic [TMO_W-1:0] tmo, logic [NOW_W-1:0] now);
        t_request q;
        q     = '0;
        q.op  = op;
        q.id  = id;
        q.tmo = tmo;
        q.now = now;
        return q;
    endfunction

    function automatic t_request rq_want(t_op op, logic [ID_W-1:0] id,
                                         logic [TMO_W-1:0] tmo,
                                         logic [NOW_W-1:0] now,
                                         logic [ID_W-1:0] given, logic expired,
                                         logic failed);
        t_request q;
        q       = rq(op, id, tmo, now);
        q.typed = 1'b1;
        q.want  = '{given, expired, failed};
        return q;
    endfunction

    // drives one request and holds it until the core takes it
    task automatic send_request(t_request q);
        i_op         <= q.op;
        i_slot_id    <= q.id;
        i_timeout_ms <= q.tmo;
        i_now_ns     <= q.now;
        req_typed    <= q.typed;
        req_want     <= q.want;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sent_n++;
    endtask

    // results are checked before the request taken at the same edge is added
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_given_slot, o_expired, o_failed};
            if (pending_results.size() == 0) begin
                $display("%0t ns: nothing pending, given_slot %0d expired %0b failed %0b",
                         $time, got.given, got.expired, got.failed);
                err_n++;
            end else begin
                want = pending_results.pop_front();
                if (got.given !== want.given) begin
                    $display("%0t ns: given_slot expected %0d actual %0d",
                             $time, want.given, got.given);
                    err_n++;
                end
                if (got.expired !== want.expired) begin
                    $display("%0t ns: expired expected %0b actual %0b",
                             $time, want.expired, got.expired);
                    err_n++;
                end
                if (got.failed !== want.failed) begin
                    $display("%0t ns: failed expected %0b actual %0b",
                             $time, want.failed, got.failed);
                    err_n++;
                end
            end
            rcv_n++;
        end
        if (i_rst_n && i_valid && o_ready) begin
            want = timer_pool_step(t_op'(i_op), i_slot_id, i_timeout_ms, i_now_ns);
            if (req_typed)
                want = req_want;
            pending_results.push_back(want);
        end
    end

    // receiver: stall patterns in segments, with a long hold-off now and then
    initial begin : result_sink
        t_stall pattern;
        int     seg;
        int     hold_at;
        hold_at = 250;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            pattern = t_stall'($urandom_range(0, 3));
            seg     = $urandom_range(8, 64);
            repeat (seg) begin
                case (pattern)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= ~i_ready;
                endcase
                @(posedge i_clk);
            end
            if (sent_n >= hold_at) begin
                // sender keeps offering, so the core backs up and drops o_ready
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_at = hold_at + 300;
            end
        end
    end

    initial begin : stimulus
        t_request         q;
        t_mix             mix;
        logic [NOW_W-1:0] clock_ns;
        logic             ignored;
        int               k;
        int               pick;
        int               round_i;
        int               round_len;
        int               burst_left;
        int               gap;
        int               rand_n;

        directed = '{
            rq_want(OP_CHECK,   6'd0,  32'd0,   63'd0,       6'd0, 1'b1, 1'b0),
            rq_want(OP_START,   6'd9,  32'd5,   63'd1000,    6'd1, 1'b0, 1'b0),
            // zero timeout: slot handed out yet stays free
            rq_want(OP_START,   6'd0,  32'd0,   63'd2000,    6'd2, 1'b0, 1'b0),
            rq_want(OP_START,   6'd0,  32'd1,   63'd3000,    6'd2, 1'b0, 1'b0),
            rq(OP_CHECK,   6'd1,  32'd0,   63'd5_000_999),
            rq(OP_CHECK,   6'd1,  32'd0,   63'd5_001_000),
            rq_want(OP_RESTART, 6'd2,  32'd0,   63'd10_000_000, 6'd0, 1'b0, 1'b0),
            rq(OP_CHECK,   6'd2,  32'd0,   63'd10_999_999),
            rq_want(OP_STOP,    6'd2,  32'd0,   63'd0,       6'd0, 1'b0, 1'b0),
            // free slot, compared against its cleared deadline
            rq(OP_CHECK,   6'd2,  32'd0,   63'd0),
            rq_want(OP_START,   6'd0,  TMO_MAX, NS_MAX,      6'd1, 1'b0, 1'b0),
            rq(OP_CHECK,   6'd1,  32'd0,   NS_MAX),
            rq_want(OP_START,   6'd63, TMO_MAX, 63'd0,       6'd1, 1'b0, 1'b0),
            rq_want(OP_START,   6'd0,  32'd3,   63'd0,       6'd2, 1'b0, 1'b0),
            // ids beyond the pool are ignored, check reports not expired
            rq_want(OP_CHECK,   6'd33, 32'd0,   NS_MAX,      6'd0, 1'b0, 1'b0),
            rq_want(OP_CHECK,   6'd63, TMO_MAX, NS_MAX,      6'd0, 1'b0, 1'b0),
            rq_want(OP_RESTART, 6'd63, 32'd0,   NS_MAX,      6'd0, 1'b0, 1'b0),
            rq_want(OP_STOP,    6'd40, 32'd0,   63'd0,       6'd0, 1'b0, 1'b0),
            rq_want(OP_RESTART, 6'd0,  TMO_MAX, NS_MAX,      6'd0, 1'b0, 1'b0),
            rq_want(OP_STOP,    6'd0,  32'd0,   63'd0,       6'd0, 1'b0, 1'b0),
            rq(OP_CHECK,   6'd1,  32'd0,   63'd4_294_967_294_999_999),
            // restart close to the top saturates the deadline
            rq(OP_RESTART, 6'd1,  32'd0,   NS_DEEP_SAT),
            rq(OP_CHECK,   6'd1,  32'd0,   NS_MAX - 63'd1),
            rq_want(OP_STOP,    6'd1,  32'd0,   63'd0,       6'd0, 1'b0, 1'b0),
            rq(OP_CHECK,   6'd32, 32'd0,   63'd0)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_N; k++)
            send_request(directed[k]);
        i_valid <= 1'b0;
        wait (rcv_n == sent_n);

        // random rounds: the first fills the pool so start runs out of slots
        clock_ns   = 63'd50_000_000_000;
        burst_left = 0;
        rand_n     = 0;
        round_i    = 0;
        while (rand_n < RAND_ITEMS) begin
            mix       = (round_i == 0) ? MIX_FILL : t_mix'($urandom_range(0, 2));
            round_len = (round_i == 0) ? 45 : $urandom_range(15, 60);
            repeat (round_len) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap > 0) begin
                        i_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                burst_left--;

                q        = '0;
                clock_ns = clock_ns + 63'($urandom_range(0, 3_000_000));
                q.now    = ($urandom_range(0, 29) == 0) ? 63'({$urandom, $urandom})
                                                        : clock_ns;
                pick     = $urandom_range(0, 9);
                q.tmo    = (pick == 0) ? 32'd0 :
                           (pick < 8)  ? 32'($urandom_range(1, 8)) : $urandom;
                q.id     = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(1, SLOTS));
                pick     = $urandom_range(0, 19);
                case (mix)
                    MIX_FILL:
                        q.op = (pick < 16) ? OP_START : t_op'($urandom_range(0, 3));
                    MIX_DRAIN:
                        q.op = (pick < 3)  ? OP_START   :
                               (pick < 7)  ? OP_RESTART :
                               (pick < 17) ? OP_CHECK   : OP_STOP;
                    default:
                        q.op = t_op'($urandom_range(0, 3));
                endcase

                send_request(q);
                ignored = (q.op != OP_START) &&
                          ((q.id > N_USE) || (q.id == '0 && q.op != OP_CHECK));
                if (!ignored)
                    rand_n++;
            end
            if (round_i == 3 || $urandom_range(0, 3) == 0) begin
                // let the pipeline run dry before the next round
                i_valid <= 1'b0;
                wait (rcv_n == sent_n);
            end
            round_i++;
        end

        i_valid <= 1'b0;
        wait (rcv_n == sent_n);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_n == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/tsp_pkg.sv
sv/tsp_free_enc.sv
sv/timer_slot_pool_core.sv
dv/tb_timer_slot_pool_core.sv
